[sv/quaternion_to_euler_yzx_assert.svh]
// Assertion macros shared by the quaternion to Euler angle modules
`ifndef QUATERNION_TO_EULER_YZX_ASSERT_SVH
`define QUATERNION_TO_EULER_YZX_ASSERT_SVH

// same-cycle implication
`define Q2E_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("q2e: check failed");

// next-cycle implication
`define Q2E_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("q2e: check failed");

`endif

[sv/q2e_pkg.sv]
// Package: widths, constants, arctangent table and shared types
package q2e_pkg;

   localparam int QUAT_WIDTH_DEF   = 16;
   localparam int ANGLE_WIDTH_DEF  = 16;
   localparam int CORDIC_STEPS_DEF = 14;

   localparam int RW  = 37;  // rotation terms, Q30
   localparam int CW  = 40;  // CORDIC vector
   localparam int ZW  = 35;  // CORDIC angle, Q30
   localparam int SW  = 32;  // clamped sine and square root, must hold +1.0
   localparam int RTW = 61;  // radicand 2^60 - s^2
   localparam int MW  = 60;  // scaled angle before rounding

   localparam logic signed [RW-1:0] ONE_Q30 = RW'(64'sd1073741824);
   localparam logic signed [ZW-1:0] PI_Q30  = ZW'(64'sd3373259426);
   localparam logic signed [24:0]   DEG_MUL = 25'sd7509872;

   typedef enum logic {
      UNIT_RAD = 1'b0,
      UNIT_DEG = 1'b1
   } angle_unit_type;

   typedef struct packed {
      logic signed [RW-1:0] roll_y;
      logic signed [RW-1:0] roll_x;
      logic signed [RW-1:0] pitch_y;
      logic signed [RW-1:0] pitch_x;
      logic signed [SW-1:0] sin;
      logic                 clip;
   } rterm_type;

   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000007;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         default: v = 32'h0;
      endcase
      return signed'(ZW'(v));
   endfunction

endpackage

[sv/q2e_rot.sv]
// Rotation matrix terms, sine clamp and asin radicand, four stages
module q2e_rot #(
   parameter int QW = q2e_pkg::QUAT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic signed [QW-1:0]           qx,
   input  logic signed [QW-1:0]           qy,
   input  logic signed [QW-1:0]           qz,
   input  logic signed [QW-1:0]           qw,
   output logic                           out_valid,
   output q2e_pkg::rterm_type             out_terms,
   output logic [q2e_pkg::RTW-1:0]        out_rad
);
`include "quaternion_to_euler_yzx_assert.svh"

   localparam int PW  = 2 * QW;
   localparam int FB  = 2 * (QW - 2);
   localparam int SHR = (FB >= 30) ? FB - 30 : 0;
   localparam int SHL = (FB >= 30) ? 0 : 30 - FB;
   localparam int RW  = q2e_pkg::RW;
   localparam int SW  = q2e_pkg::SW;
   localparam int RTW = q2e_pkg::RTW;

   function automatic logic signed [RW-1:0] to_q30(input logic signed [PW-1:0] p);
      logic signed [63:0] w;
      w = 64'(p);
      if (FB >= 30) w = w >>> SHR;
      else          w = w <<< SHL;
      return w[RW-1:0];
   endfunction

   logic [3:0] vld_ff;

   logic signed [PW-1:0] xx_ff, yy_ff, zz_ff, xy_ff, zw_ff, xz_ff, yw_ff, yz_ff, xw_ff;
   logic signed [RW-1:0] r11_ff, r21_ff, r31_ff, r22_ff, r23_ff;
   logic signed [RW-1:0] r11_in, r21_in, r31_in, r22_in, r23_in;
   q2e_pkg::rterm_type   t3_ff, t3_in, t4_ff;
   logic [RTW-1:0]       rad_ff, rad_in;
   logic signed [2*SW-1:0] sq;

   always_comb begin
      r11_in = q2e_pkg::ONE_Q30 - ((to_q30(yy_ff) + to_q30(zz_ff)) <<< 1);
      r21_in = (to_q30(xy_ff) + to_q30(zw_ff)) <<< 1;
      r31_in = (to_q30(xz_ff) - to_q30(yw_ff)) <<< 1;
      r22_in = q2e_pkg::ONE_Q30 - ((to_q30(xx_ff) + to_q30(zz_ff)) <<< 1);
      r23_in = (to_q30(yz_ff) - to_q30(xw_ff)) <<< 1;
   end

   // saturate the asin argument to plus or minus one
   always_comb begin
      t3_in.roll_y  = -r23_ff;
      t3_in.roll_x  = r22_ff;
      t3_in.pitch_y = -r31_ff;
      t3_in.pitch_x = r11_ff;
      t3_in.clip    = 1'b0;
      if (r21_ff > q2e_pkg::ONE_Q30) begin
         t3_in.sin  = SW'(q2e_pkg::ONE_Q30);
         t3_in.clip = 1'b1;
      end else if (r21_ff < -q2e_pkg::ONE_Q30) begin
         t3_in.sin  = -SW'(q2e_pkg::ONE_Q30);
         t3_in.clip = 1'b1;
      end else begin
         t3_in.sin  = r21_ff[SW-1:0];
      end
   end

   always_comb begin
      sq     = t3_ff.sin * t3_ff.sin;
      rad_in = (RTW'(1) << (RTW - 1)) - RTW'(sq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
      if (adv) begin
         xx_ff <= qx * qx;  yy_ff <= qy * qy;  zz_ff <= qz * qz;
         xy_ff <= qx * qy;  zw_ff <= qz * qw;  xz_ff <= qx * qz;
         yw_ff <= qy * qw;  yz_ff <= qy * qz;  xw_ff <= qx * qw;
         r11_ff <= r11_in;  r21_ff <= r21_in;  r31_ff <= r31_in;
         r22_ff <= r22_in;  r23_ff <= r23_in;
         t3_ff  <= t3_in;
         t4_ff  <= t3_ff;
         rad_ff <= rad_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_terms = t4_ff;
   assign out_rad   = rad_ff;

   `Q2E_ASSERT_IMP(a_clip_mag, clock, reset, vld_ff[2] && t3_ff.clip,
      t3_ff.sin == SW'(q2e_pkg::ONE_Q30) || t3_ff.sin == -SW'(q2e_pkg::ONE_Q30))
   `Q2E_ASSERT_IMP(a_rad_zero, clock, reset, vld_ff[3],
      (rad_ff == '0) == (t4_ff.sin == SW'(q2e_pkg::ONE_Q30) ||
                         t4_ff.sin == -SW'(q2e_pkg::ONE_Q30)))

endmodule

[sv/q2e_isqrt.sv]
// Pipelined integer square root, one result bit per stage, with side payload
module q2e_isqrt #(
   parameter int PW = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [q2e_pkg::RTW-1:0]     in_rad,
   input  logic [PW-1:0]               in_pl,
   output logic                        out_valid,
   output logic [q2e_pkg::SW-1:0]      out_root,
   output logic [PW-1:0]               out_pl
);
`include "quaternion_to_euler_yzx_assert.svh"

   localparam int RTW = q2e_pkg::RTW;
   localparam int NS  = (RTW + 1) / 2;

   logic [RTW-1:0] rem_ff  [1:NS];
   logic [RTW:0]   root_ff [1:NS];
   logic [PW-1:0]  pl_ff   [1:NS];
   logic [NS:1]    vld_ff;

   logic [RTW-1:0] rem_cur  [0:NS-1];
   logic [RTW:0]   root_cur [0:NS-1];
   logic [PW-1:0]  pl_cur   [0:NS-1];
   logic [NS-1:0]  vld_cur;
   logic [RTW-1:0] rem_in   [0:NS-1];
   logic [RTW:0]   root_in  [0:NS-1];

   always_comb begin
      rem_cur[0]  = in_rad;
      root_cur[0] = '0;
      pl_cur[0]   = in_pl;
      vld_cur[0]  = in_valid;
      for (int k = 1; k < NS; k++) begin
         rem_cur[k]  = rem_ff[k];
         root_cur[k] = root_ff[k];
         pl_cur[k]   = pl_ff[k];
         vld_cur[k]  = vld_ff[k];
      end
   end

   // stage k tries the bit of weight 4^(NS-1-k)
   always_comb begin
      for (int k = 0; k < NS; k++) begin
         if ({1'b0, rem_cur[k]} >= root_cur[k] + ((RTW + 1)'(1) << (RTW - 1 - 2 * k))) begin
            rem_in[k]  = rem_cur[k] - RTW'(root_cur[k] +
                         ((RTW + 1)'(1) << (RTW - 1 - 2 * k)));
            root_in[k] = (root_cur[k] >> 1) + ((RTW + 1)'(1) << (RTW - 1 - 2 * k));
         end else begin
            rem_in[k]  = rem_cur[k];
            root_in[k] = root_cur[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_cur;
      end
      if (adv) begin
         for (int k = 0; k < NS; k++) begin
            rem_ff[k+1]  <= rem_in[k];
            root_ff[k+1] <= root_in[k];
            pl_ff[k+1]   <= pl_cur[k];
         end
      end
   end

   assign out_valid = vld_ff[NS];
   assign out_root  = root_ff[NS][q2e_pkg::SW-1:0];
   assign out_pl    = pl_ff[NS];

   `Q2E_ASSERT_IMP(a_root_max, clock, reset, vld_ff[NS],
      root_ff[NS] <= ((RTW + 1)'(1) << (q2e_pkg::SW - 1)))
   `Q2E_ASSERT_IMP(a_root_rem, clock, reset, vld_ff[NS],
      {1'b0, rem_ff[NS]} <= (root_ff[NS] << 1))
   `Q2E_ASSERT_NXT(a_hold_item, clock, reset, vld_ff[NS] && !adv, vld_ff[NS])

endmodule

[sv/q2e_cordic.sv]
// Pipelined vectoring CORDIC: atan2(y, x) in Q30, one rotation per stage
module q2e_cordic #(
   parameter int STEPS = q2e_pkg::CORDIC_STEPS_DEF,
   parameter int PW    = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_valid,
   input  logic signed [q2e_pkg::CW-1:0]      in_y,
   input  logic signed [q2e_pkg::CW-1:0]      in_x,
   input  logic [PW-1:0]                      in_pl,
   output logic                               out_valid,
   output logic signed [q2e_pkg::ZW-1:0]      out_angle,
   output logic [PW-1:0]                      out_pl
);

   localparam int N  = (STEPS < 30) ? STEPS : 30;
   localparam int CW = q2e_pkg::CW;
   localparam int ZW = q2e_pkg::ZW;

   logic signed [CW-1:0] x_ff [0:N], x_in [0:N];
   logic signed [CW-1:0] y_ff [0:N], y_in [0:N];
   logic signed [ZW-1:0] z_ff [0:N], z_in [0:N];
   logic [PW-1:0]        pl_ff [0:N];
   logic [N:0]           zero_ff;
   logic [N:0]           vld_ff;

   // pre-turn by pi for vectors in the left half plane
   always_comb begin
      if (in_x < 0) begin
         x_in[0] = -in_x;
         y_in[0] = -in_y;
         z_in[0] = (in_y >= 0) ? q2e_pkg::PI_Q30 : -q2e_pkg::PI_Q30;
      end else begin
         x_in[0] = in_x;
         y_in[0] = in_y;
         z_in[0] = '0;
      end
      for (int k = 0; k < N; k++) begin
         if (y_ff[k] >= 0) begin
            x_in[k+1] = x_ff[k] + (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] - (x_ff[k] >>> k);
            z_in[k+1] = z_ff[k] + q2e_pkg::atan_q30(5'(k));
         end else begin
            x_in[k+1] = x_ff[k] - (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] + (x_ff[k] >>> k);
            z_in[k+1] = z_ff[k] - q2e_pkg::atan_q30(5'(k));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[N-1:0], in_valid};
      end
      if (adv) begin
         zero_ff <= {zero_ff[N-1:0], (in_x == '0) && (in_y == '0)};
         pl_ff[0] <= in_pl;
         for (int k = 0; k <= N; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
         end
         for (int k = 1; k <= N; k++) begin
            pl_ff[k] <= pl_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_angle = zero_ff[N] ? '0 : z_ff[N];
   assign out_pl    = pl_ff[N];

endmodule

[sv/q2e_scale.sv]
// Unit scaling, rounding and saturation of the three angles, two stages
module q2e_scale #(
   parameter int AW = q2e_pkg::ANGLE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  q2e_pkg::angle_unit_type         unit,
   input  logic signed [q2e_pkg::ZW-1:0]   in_roll,
   input  logic signed [q2e_pkg::ZW-1:0]   in_pitch,
   input  logic signed [q2e_pkg::ZW-1:0]   in_yaw,
   input  logic                            in_clip,
   output logic                            out_valid,
   output logic signed [AW-1:0]            out_roll,
   output logic signed [AW-1:0]            out_pitch,
   output logic signed [AW-1:0]            out_yaw,
   output logic                            out_clip
);

   localparam int MW = q2e_pkg::MW;
   localparam logic signed [63:0] HI = (64'sd1 <<< (AW - 1)) - 64'sd1;
   localparam logic signed [63:0] LO = -HI - 64'sd1;

   // radians take the same rounding as degrees after a shift by 22
   function automatic logic signed [MW-1:0] scale(input logic signed [q2e_pkg::ZW-1:0] a,
                                                  input q2e_pkg::angle_unit_type u);
      logic signed [MW-1:0] e;
      e = MW'(a);
      if (u == q2e_pkg::UNIT_DEG) return e * MW'(q2e_pkg::DEG_MUL);
      else                        return e <<< 22;
   endfunction

   function automatic logic signed [AW-1:0] round_sat(input logic signed [MW-1:0] m);
      logic signed [63:0] v;
      v = (64'(m) + (64'sd1 <<< 39)) >>> 40;
      if (v > HI)      v = HI;
      else if (v < LO) v = LO;
      return v[AW-1:0];
   endfunction

   logic signed [MW-1:0] roll_ff, pitch_ff, yaw_ff;
   logic                 clip_ff;
   logic [1:0]           vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[0], in_valid};
      end
      if (adv) begin
         roll_ff   <= scale(in_roll, unit);
         pitch_ff  <= scale(in_pitch, unit);
         yaw_ff    <= scale(in_yaw, unit);
         clip_ff   <= in_clip;
         out_roll  <= round_sat(roll_ff);
         out_pitch <= round_sat(pitch_ff);
         out_yaw   <= round_sat(yaw_ff);
         out_clip  <= clip_ff;
      end
   end

   assign out_valid = vld_ff[1];

endmodule

[sv/quaternion_to_euler_yzx.sv]
// Top level: quaternion to Euler angles in YZX order, fully pipelined
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_quat_x/y/z/w
//  rsp     | out       | rsp_valid/rsp_stall | rsp_roll_x, rsp_pitch_y, rsp_yaw_z, rsp_clamped
//  csr     | in        | csr_valid/csr_ready | csr_angle_unit
//
// One item per cycle while no held result stalls the pipeline; an item passes the
// rotation stages, the 31-stage square root, CORDIC and scaling stages in order.
// Reset clears the valid bits and sets the unit to degrees; no clearing pass.
// A held result freezes the whole pipeline, so req_stall follows rsp_stall
// while a result waits; bubbles still move forward otherwise.
module quaternion_to_euler_yzx #(
   parameter int QUAT_WIDTH   = q2e_pkg::QUAT_WIDTH_DEF,
   parameter int ANGLE_WIDTH  = q2e_pkg::ANGLE_WIDTH_DEF,
   parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [QUAT_WIDTH-1:0]  req_quat_x,
   input  logic signed [QUAT_WIDTH-1:0]  req_quat_y,
   input  logic signed [QUAT_WIDTH-1:0]  req_quat_z,
   input  logic signed [QUAT_WIDTH-1:0]  req_quat_w,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [ANGLE_WIDTH-1:0] rsp_roll_x,
   output logic signed [ANGLE_WIDTH-1:0] rsp_pitch_y,
   output logic signed [ANGLE_WIDTH-1:0] rsp_yaw_z,
   output logic                          rsp_clamped,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_angle_unit
);
`include "quaternion_to_euler_yzx_assert.svh"

   localparam int CW = q2e_pkg::CW;
   localparam int PW = $bits(q2e_pkg::rterm_type);

   q2e_pkg::angle_unit_type unit_ff;
   logic                    adv;

   logic                    rot_valid;
   q2e_pkg::rterm_type      rot_terms;
   logic [q2e_pkg::RTW-1:0] rot_rad;

   logic                    sq_valid;
   logic [q2e_pkg::SW-1:0]  sq_root;
   logic [PW-1:0]           sq_pl;
   q2e_pkg::rterm_type      sq_terms;

   logic                        yaw_valid, yaw_clip;
   logic                        roll_valid, roll_clip, pitch_valid, pitch_clip;
   logic signed [q2e_pkg::ZW-1:0] roll_a, pitch_a, yaw_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= q2e_pkg::UNIT_DEG;
      end else if (csr_valid && csr_ready) begin
         unit_ff <= q2e_pkg::angle_unit_type'(csr_angle_unit);
      end
   end

   assign csr_ready = 1'b1;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   q2e_rot #(.QW(QUAT_WIDTH)) u_rot (
      .clock, .reset, .adv,
      .in_valid (req_valid),
      .qx (req_quat_x), .qy (req_quat_y), .qz (req_quat_z), .qw (req_quat_w),
      .out_valid (rot_valid), .out_terms (rot_terms), .out_rad (rot_rad)
   );

   q2e_isqrt #(.PW(PW)) u_isqrt (
      .clock, .reset, .adv,
      .in_valid (rot_valid), .in_rad (rot_rad), .in_pl (rot_terms),
      .out_valid (sq_valid), .out_root (sq_root), .out_pl (sq_pl)
   );

   assign sq_terms = q2e_pkg::rterm_type'(sq_pl);

   q2e_cordic #(.STEPS(CORDIC_STEPS), .PW(1)) u_roll (
      .clock, .reset, .adv,
      .in_valid (sq_valid),
      .in_y (CW'(sq_terms.roll_y)), .in_x (CW'(sq_terms.roll_x)), .in_pl (sq_terms.clip),
      .out_valid (roll_valid), .out_angle (roll_a), .out_pl (roll_clip)
   );

   q2e_cordic #(.STEPS(CORDIC_STEPS), .PW(1)) u_pitch (
      .clock, .reset, .adv,
      .in_valid (sq_valid),
      .in_y (CW'(sq_terms.pitch_y)), .in_x (CW'(sq_terms.pitch_x)), .in_pl (sq_terms.clip),
      .out_valid (pitch_valid), .out_angle (pitch_a), .out_pl (pitch_clip)
   );

   // asin(s) as atan2(s, sqrt(1 - s^2))
   q2e_cordic #(.STEPS(CORDIC_STEPS), .PW(1)) u_yaw (
      .clock, .reset, .adv,
      .in_valid (sq_valid),
      .in_y (CW'(sq_terms.sin)), .in_x (signed'(CW'(sq_root))), .in_pl (sq_terms.clip),
      .out_valid (yaw_valid), .out_angle (yaw_a), .out_pl (yaw_clip)
   );

   q2e_scale #(.AW(ANGLE_WIDTH)) u_scale (
      .clock, .reset, .adv,
      .in_valid (yaw_valid), .unit (unit_ff),
      .in_roll (roll_a), .in_pitch (pitch_a), .in_yaw (yaw_a), .in_clip (yaw_clip),
      .out_valid (rsp_valid),
      .out_roll (rsp_roll_x), .out_pitch (rsp_pitch_y), .out_yaw (rsp_yaw_z),
      .out_clip (rsp_clamped)
   );

   // the three CORDIC lanes run in lock step
   `Q2E_ASSERT_IMP(a_lane_valid, clock, reset, 1'b1,
      roll_valid == yaw_valid && pitch_valid == yaw_valid)
   `Q2E_ASSERT_IMP(a_lane_item, clock, reset, yaw_valid,
      roll_clip == yaw_clip && pitch_clip == yaw_clip)
   `Q2E_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule
